/* rtl/hrrn_pkg.sv */
// ----------------------------------------------------------------------------
// hrrn_pkg
// types and constants shared by the ready queue scheduler
// ----------------------------------------------------------------------------
package hrrn_pkg;

	localparam int OP_W   = 2;
	localparam int ID_W   = 8;
	localparam int EST_W  = 16;
	localparam int WAIT_W = 24;
	localparam int ALPHA_W = 9;

	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 2'd0,
		OP_ENQUEUE = 2'd1,
		OP_SELECT  = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_GRANT = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [1:0] CFG_MODE  = 2'd0;
	localparam logic [1:0] CFG_INIT  = 2'd1;
	localparam logic [1:0] CFG_ALPHA = 2'd2;

	localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  process_id;
		logic [EST_W-1:0] prior_estimate;
		logic [EST_W-1:0] prior_burst;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  granted_id;
		logic [EST_W-1:0] new_estimate;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  process_id;
		logic [EST_W-1:0] estimate;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       index;
		logic [EST_W-1:0] data;
	} cfg_item_t;

endpackage

/* rtl/hrrn_if.sv */
// ----------------------------------------------------------------------------
// hrrn_if
// valid/ready channels for items, results and configuration
// ----------------------------------------------------------------------------
interface hrrn_in_if;
	import hrrn_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hrrn_out_if;
	import hrrn_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface hrrn_cfg_if;
	import hrrn_pkg::*;
	logic valid;
	logic ready;
	cfg_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/hrrn_front.sv */
// ----------------------------------------------------------------------------
// hrrn_front
// accepts items, forms the effective estimate, pushes commands to the queue
// ----------------------------------------------------------------------------
module hrrn_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  hrrn_pkg::in_item_t        in_data,
	input  logic [hrrn_pkg::EST_W-1:0]   initial_estimate,
	input  logic [hrrn_pkg::ALPHA_W-1:0] alpha_q8,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output hrrn_pkg::cmd_t            cmd
);
	import hrrn_pkg::*;

	// stage 1: products registered; sum and round formed combinationally from it
	logic              s1_valid_q;
	logic [24:0]       burst_prod_s1;
	logic [24:0]       est_prod_s1;
	logic              use_init_s1;
	op_t               op_s1;
	logic [ID_W-1:0]   id_s1;
	logic [EST_W-1:0]  init_s1;
	logic [8:0]        a;
	logic [8:0]        a_inv;
	logic [25:0]       sum;

	assign a      = (alpha_q8 > 9'd256) ? 9'd256 : alpha_q8;
	assign a_inv  = 9'd256 - a;
	assign in_ready = !s1_valid_q || cmd_ready;
	assign sum = {1'b0, burst_prod_s1} + {1'b0, est_prod_s1} + 26'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			burst_prod_s1 <= a * in_data.prior_burst;
			est_prod_s1   <= a_inv * in_data.prior_estimate;
			use_init_s1   <= (in_data.prior_estimate == '0);
			op_s1         <= in_data.op;
			id_s1         <= in_data.process_id;
			init_s1       <= initial_estimate;
		end
	end

	assign cmd_valid      = s1_valid_q;
	assign cmd.op         = op_s1;
	assign cmd.process_id = id_s1;
	assign cmd.estimate   = use_init_s1 ? init_s1 : sum[23:8];

endmodule

/* rtl/hrrn_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// hrrn_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module hrrn_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  hrrn_pkg::cmd_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output hrrn_pkg::cmd_t rd_data
);
	import hrrn_pkg::*;

	cmd_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = slot_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= wr_data;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("command queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> count_q == 2'd2)
		else $error("command queue lost an entry");

endmodule

/* rtl/hrrn_back.sv */
// ----------------------------------------------------------------------------
// hrrn_back
// ready queue storage, aging, ratio scan and compaction
// ----------------------------------------------------------------------------
module hrrn_back #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  hrrn_pkg::cmd_t     cmd,
	input  logic               scheduling_mode,
	output logic               res_valid,
	input  logic               res_ready,
	output hrrn_pkg::out_item_t res
);
	import hrrn_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_TICK, S_SCAN, S_MUL, S_SHIFT, S_DONE, S_COMPACT
	} state_t;

	logic [ID_W-1:0]   pid_mem  [QUEUE_DEPTH];
	logic [EST_W-1:0]  est_mem  [QUEUE_DEPTH];
	logic [WAIT_W-1:0] wait_mem [QUEUE_DEPTH];

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  best_q;
	logic [ID_W-1:0]   best_pid_q;
	logic [EST_W-1:0]  best_est_q;
	logic [WAIT_W-1:0] best_wait_q;
	logic [ID_W-1:0]   cur_pid_q;
	logic [EST_W-1:0]  cur_est_q;
	logic [WAIT_W-1:0] cur_wait_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic [39:0]       lhs_q;
	logic [39:0]       rhs_q;
	logic              res_valid_q;
	out_item_t         res_q;
	logic [IDX_W-1:0]  ix;
	logic [IDX_W-1:0]  ixn;
	logic              compact_end;

	assign ix  = idx_q[IDX_W-1:0];
	assign ixn = IDX_W'(idx_q + 1'b1);
	assign cmd_ready = (state_q == S_IDLE) && !res_valid_q;
	assign res_valid = res_valid_q;
	assign res = res_q;
	// compaction walks from the granted entry upward, one entry a cycle
	assign compact_end = (idx_q + 1'b1 >= count_q);

	// one entry a cycle for tick and compaction; select scan reads one entry,
	// then cross multiplies in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						case (cmd.op)
							OP_TICK: begin
								res_q <= '{status: ST_OK, granted_id: '0, new_estimate: '0};
								idx_q <= '0;
								if (count_q != '0) state_q <= S_TICK;
								else res_valid_q <= 1'b1;
							end
							OP_ENQUEUE: begin
								res_valid_q <= 1'b1;
								if (count_q == DEPTH_C) begin
									res_q <= '{status: ST_FULL, granted_id: '0,
										new_estimate: '0};
								end else begin
									res_q <= '{status: ST_OK, granted_id: '0,
										new_estimate: '0};
									count_q <= count_q + 1'b1;
								end
							end
							OP_SELECT: begin
								if (count_q == '0) begin
									res_q <= '{status: ST_EMPTY, granted_id: '0,
										new_estimate: '0};
									res_valid_q <= 1'b1;
								end else begin
									best_q      <= '0;
									best_pid_q  <= pid_mem[0];
									best_est_q  <= est_mem[0];
									best_wait_q <= wait_mem[0];
									idx_q       <= CNT_W'(1);
									state_q     <= scheduling_mode ? S_SCAN : S_DONE;
								end
							end
							default: begin
								res_q <= '{status: ST_OK, granted_id: '0, new_estimate: '0};
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_TICK: begin
					if (idx_q + 1'b1 == count_q) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				S_SCAN: begin
					if (idx_q >= count_q) begin
						state_q <= S_DONE;
					end else begin
						cur_pid_q  <= pid_mem[ix];
						cur_est_q  <= est_mem[ix];
						cur_wait_q <= wait_mem[ix];
						cur_idx_q  <= ix;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					lhs_q   <= cur_wait_q * best_est_q;
					rhs_q   <= best_wait_q * cur_est_q;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					// compare registered products, then move on
					if (lhs_q > rhs_q) begin
						best_q      <= cur_idx_q;
						best_pid_q  <= cur_pid_q;
						best_est_q  <= cur_est_q;
						best_wait_q <= cur_wait_q;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_DONE: begin
					// latch the grant and load the compaction start
					res_q <= '{status: ST_GRANT, granted_id: best_pid_q,
						new_estimate: best_est_q};
					idx_q   <= CNT_W'(best_q);
					state_q <= S_COMPACT;
				end
				S_COMPACT: begin
					if (compact_end) begin
						state_q     <= S_IDLE;
						count_q     <= count_q - 1'b1;
						res_valid_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd_ready && cmd.op == OP_ENQUEUE &&
			count_q != DEPTH_C) begin
			pid_mem[count_q[IDX_W-1:0]]  <= cmd.process_id;
			est_mem[count_q[IDX_W-1:0]]  <= cmd.estimate;
			wait_mem[count_q[IDX_W-1:0]] <= '0;
		end else if (state_q == S_TICK) begin
			if (wait_mem[ix] != WAIT_MAX) wait_mem[ix] <= wait_mem[ix] + 1'b1;
		end else if (state_q == S_COMPACT && !compact_end) begin
			pid_mem[ix]  <= pid_mem[ixn];
			est_mem[ix]  <= est_mem[ixn];
			wait_mem[ix] <= wait_mem[ixn];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("entry count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_ready) |=> res_valid_q && $stable(res_q))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT && compact_end) |=> count_q == $past(count_q) - 1'b1)
		else $error("select did not shrink the queue");

endmodule

/* rtl/hrrn_ready_queue_scheduler_top.sv */
// ----------------------------------------------------------------------------
// hrrn_ready_queue_scheduler_top
// ready queue scheduler, fifo or highest response ratio selection
// ----------------------------------------------------------------------------
// channel | role  | payload
// in_ch   | sink  | operation, process_id, prior_estimate, prior_burst
// out_ch  | source| status, granted_id, new_estimate
// cfg_ch  | sink  | register index, write data
//
// enqueue, full, empty and unused op: the back registers the result once the command leaves the queue
// tick: one entry aged per cycle
// select oldest first: compaction moves one entry a cycle
// select highest ratio: each entry after the first is read, cross multiplied and
// compared against the best so far by the shared cross multiply compare
// arst_n clears control state and loads the register reset values
// a waiting result holds the back; the front keeps accepting up to its stage
// register and the two-entry queue
module hrrn_ready_queue_scheduler_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	hrrn_in_if.sink   in_ch,
	hrrn_out_if.source out_ch,
	hrrn_cfg_if.sink  cfg_ch
);
	import hrrn_pkg::*;

	logic               mode_q;
	logic [EST_W-1:0]   init_est_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic               f_valid;
	logic               f_ready;
	cmd_t               f_cmd;
	logic               b_valid;
	logic               b_ready;
	cmd_t               b_cmd;

	// config writes always taken
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b1;
			init_est_q <= EST_W'(10000);
			alpha_q    <= ALPHA_W'(128);
		end else if (cfg_ch.valid) begin
			case (cfg_ch.data.index)
				CFG_MODE:  mode_q     <= cfg_ch.data.data[0];
				CFG_INIT:  init_est_q <= cfg_ch.data.data;
				CFG_ALPHA: alpha_q    <= cfg_ch.data.data[ALPHA_W-1:0];
				default:   ;
			endcase
		end
	end

	// front: products of the exponential average
	hrrn_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.initial_estimate(init_est_q), .alpha_q8(alpha_q),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	hrrn_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
	);

	// back: queue storage and selection
	hrrn_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.scheduling_mode(mode_q),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
	);

endmodule
